// ----- sv/sss_pkg.sv -----
package sss_pkg;

	// Number of hidden-state elements per time step (1..256).
	localparam int STATE_DIM = 16;
	localparam int IDX_W     = (STATE_DIM > 1) ? $clog2(STATE_DIM) : 1;

	// Field widths, fixed by the item format.
	localparam int D_W = 16;   // decay, input_term, readout
	localparam int H_W = 24;   // hidden state, Q11.12
	localparam int Y_W = 32;   // scan value, Q19.12

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_A,
		ST_UPD_H,
		ST_MUL_C,
		ST_ACC
	} state_t;

	typedef enum logic {
		MUL_DECAY,
		MUL_READOUT
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     h_write;
		logic     step;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic last;
	} status_t;

endpackage

// ----- sv/sss_in_if.sv -----
interface sss_in_if;
	logic                                  valid;
	logic                                  ready;
	logic        [sss_pkg::D_W-1:0]        decay;
	logic signed [sss_pkg::D_W-1:0]        input_term;
	logic signed [sss_pkg::D_W-1:0]        readout;
	logic                                  new_sequence;

	modport source (
		output valid, decay, input_term, readout, new_sequence,
		input  ready
	);

	modport sink (
		input  valid, decay, input_term, readout, new_sequence,
		output ready
	);
endinterface

// ----- sv/sss_out_if.sv -----
interface sss_out_if;
	logic                           valid;
	logic                           ready;
	logic signed [sss_pkg::Y_W-1:0] scan_value;

	modport source (
		output valid, scan_value,
		input  ready
	);

	modport sink (
		input  valid, scan_value,
		output ready
	);
endinterface

// ----- sv/sss_ctrl.sv -----
module sss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  sss_pkg::status_t status,
	output sss_pkg::cmd_t    cmd
);

	sss_pkg::state_t state_q, state_next;
	logic            out_valid_q;
	logic            out_free;
	logic            acc_done;

	assign out_free = !out_valid_q || out_ready;
	// last element waits here only while the previous result is untaken
	assign acc_done = !status.last || out_free;

	always_comb begin
		state_next = state_q;
		case (state_q)
			sss_pkg::ST_IDLE: begin
				if (in_valid) state_next = sss_pkg::ST_MUL_A;
			end
			sss_pkg::ST_MUL_A: state_next = sss_pkg::ST_UPD_H;
			sss_pkg::ST_UPD_H: state_next = sss_pkg::ST_MUL_C;
			sss_pkg::ST_MUL_C: state_next = sss_pkg::ST_ACC;
			sss_pkg::ST_ACC: begin
				if (acc_done) state_next = sss_pkg::ST_IDLE;
			end
			default: state_next = sss_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.mul_sel  = sss_pkg::MUL_DECAY;
		in_ready     = 1'b0;
		case (state_q)
			sss_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sss_pkg::ST_MUL_A: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = sss_pkg::MUL_DECAY;
			end
			sss_pkg::ST_UPD_H: begin
				cmd.h_write = 1'b1;
			end
			sss_pkg::ST_MUL_C: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = sss_pkg::MUL_READOUT;
			end
			sss_pkg::ST_ACC: begin
				cmd.step     = acc_done;
				cmd.out_load = status.last && out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sss_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sv/sss_datapath.sv -----
module sss_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic        [sss_pkg::D_W-1:0]  decay,
	input  logic signed [sss_pkg::D_W-1:0]  input_term,
	input  logic signed [sss_pkg::D_W-1:0]  readout,
	input  logic                            new_sequence,
	input  sss_pkg::cmd_t                   cmd,
	output sss_pkg::status_t                status,
	output logic signed [sss_pkg::Y_W-1:0]  scan_value
);

	localparam int PROD_W = sss_pkg::D_W + 1 + sss_pkg::H_W;

	// item registers
	logic        [sss_pkg::D_W-1:0] decay_q;
	logic signed [sss_pkg::D_W-1:0] bu_q;
	logic signed [sss_pkg::D_W-1:0] c_q;
	logic                           first_q;

	// hidden-state store, valid bits stand in for the reset-to-zero
	logic        [sss_pkg::H_W-1:0]     hmem [sss_pkg::STATE_DIM];
	logic        [sss_pkg::STATE_DIM-1:0] hvalid_q;
	logic signed [sss_pkg::H_W-1:0]     rd_q;

	logic        [sss_pkg::IDX_W-1:0]   idx_q;
	logic signed [PROD_W-1:0]           prod_q;
	logic signed [sss_pkg::H_W-1:0]     h_q;
	logic signed [sss_pkg::Y_W-1:0]     acc_q;
	logic signed [sss_pkg::Y_W-1:0]     res_q;

	logic signed [sss_pkg::H_W-1:0]     prior;
	logic signed [sss_pkg::D_W:0]       op_a;
	logic signed [sss_pkg::H_W-1:0]     op_b;
	logic        [PROD_W:0]             hr;
	logic        [PROD_W:0]             cr;
	logic        [27:0]                 hs;
	logic        [sss_pkg::H_W-1:0]     h_next;
	logic        [29:0]                 cs;
	logic        [sss_pkg::Y_W-1:0]     base;
	logic        [sss_pkg::Y_W:0]       ys;
	logic        [sss_pkg::Y_W-1:0]     acc_next;

	assign status.last = (idx_q == sss_pkg::IDX_W'(sss_pkg::STATE_DIM - 1));

	always_comb begin
		prior = (first_q || !hvalid_q[idx_q]) ? '0 : rd_q;

		if (cmd.mul_sel == sss_pkg::MUL_DECAY) begin
			op_a = $signed({1'b0, decay_q});
			op_b = prior;
		end else begin
			op_a = $signed({c_q[sss_pkg::D_W-1], c_q});
			op_b = h_q;
		end

		// h = floor((a*h_prev + 2^14) / 2^15) + bu, saturated to 24 bits
		hr = {prod_q[PROD_W-1], prod_q} + (PROD_W+1)'(16384);
		hs = {hr[PROD_W], hr[PROD_W:15]} + {{12{bu_q[sss_pkg::D_W-1]}}, bu_q};
		if (hs[27:23] == {5{hs[23]}}) h_next = hs[23:0];
		else if (hs[27])              h_next = 24'h800000;
		else                          h_next = 24'h7FFFFF;

		// contribution = floor((c*h + 2^11) / 2^12); accumulate, saturated
		cr   = {prod_q[PROD_W-1], prod_q} + (PROD_W+1)'(2048);
		cs   = cr[41:12];
		base = (idx_q == '0) ? '0 : acc_q;
		ys   = {base[sss_pkg::Y_W-1], base} + {{3{cs[29]}}, cs};
		if (ys[32] == ys[31]) acc_next = ys[31:0];
		else if (ys[32])      acc_next = 32'h80000000;
		else                  acc_next = 32'h7FFFFFFF;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			decay_q <= decay;
			bu_q    <= input_term;
			c_q     <= readout;
			first_q <= new_sequence;
		end
		if (cmd.h_write) hmem[idx_q] <= h_next;
		rd_q <= hmem[idx_q];
		if (cmd.mul_en) prod_q <= op_a * op_b;
		if (cmd.h_write) h_q <= h_next;
		if (cmd.out_load) res_q <= acc_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
			idx_q    <= '0;
			acc_q    <= '0;
		end else begin
			if (cmd.h_write) hvalid_q[idx_q] <= 1'b1;
			if (cmd.step) begin
				acc_q <= acc_next;
				if (status.last) idx_q <= '0;
				else             idx_q <= idx_q + sss_pkg::IDX_W'(1);
			end
		end
	end

	assign scan_value = res_q;

endmodule

// ----- sv/selective_state_scan_core.sv -----
// Channel   Direction  Payload                                        Transaction
// items     in         decay, input_term, readout, new_sequence       one state element
// results   out        scan_value                                     one per time step
//
// Each element is accepted in IDLE, then runs MUL_A, UPD_H, MUL_C, ACC. One 17x24
// multiplier is shared by the two dependent products (decay*h, then readout*h),
// each registered before use, and the hidden state is read from a registered RAM.
// Reset clears the FSM, element index, accumulator and the per-entry valid bits;
// an entry never written reads as zero, so no clearing pass is needed.
// A result sits in an output register; items keep flowing while it waits. Only the
// last element of the next time step holds if that result is still untaken.
module selective_state_scan_core (
	input  logic       clk,
	input  logic       arst_n,
	sss_in_if.sink     items,
	sss_out_if.source  results
);

	sss_pkg::cmd_t    cmd;
	sss_pkg::status_t status;

	// sequencing: one element in flight, steps driven by the FSM
	sss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (items.valid),
		.in_ready  (items.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// state store, shared multiplier, rounding/saturation and accumulator
	sss_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.decay        (items.decay),
		.input_term   (items.input_term),
		.readout      (items.readout),
		.new_sequence (items.new_sequence),
		.cmd          (cmd),
		.status       (status),
		.scan_value   (results.scan_value)
	);

	// a result is loaded only on the last element of a time step
	a_out_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> status.last)
		else $error("result loaded on a non-final element");

	// a loaded result shows up as valid on the next cycle
	a_out_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> results.valid)
		else $error("loaded result not presented");

	// one element at a time: no back-to-back accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(items.valid && items.ready) |=> !items.ready)
		else $error("accepted a transaction while busy");

	// the state update always follows the decay product
	a_h_after_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.h_write |-> $past(cmd.mul_en))
		else $error("state written without a fresh product");

endmodule
